/* hw/rtl/multi_lane_led_waveform_gen_assert.svh */
// Assertion macros shared by the LED waveform generator RTL.
`ifndef MULTI_LANE_LED_WAVEFORM_GEN_ASSERT_SVH
`define MULTI_LANE_LED_WAVEFORM_GEN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MLWG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlwg assertion failed");

// Next-cycle implication, disabled during reset.
`define MLWG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlwg assertion failed");

`endif

/* hw/rtl/mlwg_pkg.sv */
package mlwg_pkg;

  localparam int unsigned PIN_W    = 32;
  localparam int unsigned LANES    = 32;
  localparam int unsigned TICK_W   = 10;
  localparam int unsigned GUARD_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Pins above the lane count are never driven.
  localparam logic [PIN_W-1:0] LANE_MASK = (LANES >= PIN_W) ? {PIN_W{1'b1}} :
                                           PIN_W'((64'd1 << LANES) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_EN    = 3'd4;

  localparam logic [TICK_W-1:0]  RST_BIT_PERIOD = 10'd60;
  localparam logic [TICK_W-1:0]  RST_ZERO_HIGH  = 10'd14;
  localparam logic [TICK_W-1:0]  RST_ONE_HIGH   = 10'd38;
  localparam logic [GUARD_W-1:0] RST_GUARD      = 16'd2640;
  localparam logic [PIN_W-1:0]   RST_LANE_EN    = '0;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_SEND  = 3'b010,
    MODE_GUARD = 3'b100
  } mode_t;

  typedef struct packed {
    logic [TICK_W-1:0]  bit_period;
    logic [TICK_W-1:0]  zero_high;
    logic [TICK_W-1:0]  one_high;
    logic [GUARD_W-1:0] guard;
    logic [PIN_W-1:0]   lane_en;
  } cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0] pins;
    logic             taken;
    logic             busy;
    logic             done;
    logic             under;
  } res_t;

endpackage

/* hw/rtl/mlwg_core.sv */
module mlwg_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  mlwg_pkg::cfg_t                 cfg,
  input  logic                           word_valid,
  input  logic [mlwg_pkg::PIN_W-1:0]     bit_plane,
  input  logic                           plane_last,
  output mlwg_pkg::res_t                 res
);

  mlwg_pkg::mode_t                   mode, mode_next;
  logic [mlwg_pkg::TICK_W-1:0]       slot_tick, slot_tick_next;
  logic [mlwg_pkg::GUARD_W-1:0]      guard_count, guard_count_next;
  logic [mlwg_pkg::PIN_W-1:0]        current_plane, current_plane_next;
  logic                              current_is_last, current_is_last_next;

  logic [mlwg_pkg::PIN_W-1:0]        en;
  logic [mlwg_pkg::PIN_W-1:0]        ones;
  logic [mlwg_pkg::PIN_W-1:0]        zeros;
  logic [mlwg_pkg::TICK_W:0]         slot_inc;
  logic [mlwg_pkg::GUARD_W:0]        guard_inc;
  logic                              slot_end;
  logic                              guard_end;

  assign en        = cfg.lane_en & mlwg_pkg::LANE_MASK;
  assign ones      = (slot_tick < cfg.one_high) ? en : '0;
  assign zeros     = ((slot_tick < cfg.zero_high) && (slot_tick < cfg.one_high)) ? en : '0;
  assign slot_inc  = {1'b0, slot_tick} + {{mlwg_pkg::TICK_W{1'b0}}, 1'b1};
  assign guard_inc = {1'b0, guard_count} + {{mlwg_pkg::GUARD_W{1'b0}}, 1'b1};
  assign slot_end  = slot_inc >= {1'b0, cfg.bit_period};
  assign guard_end = guard_inc >= {1'b0, cfg.guard};

  always_comb begin
    mode_next            = mode;
    slot_tick_next       = slot_tick;
    guard_count_next     = guard_count;
    current_plane_next   = current_plane;
    current_is_last_next = current_is_last;
    res                  = '0;
    unique case (mode)
      mlwg_pkg::MODE_SEND: begin
        res.busy = 1'b1;
        res.pins = ((ones & current_plane) | (zeros & ~current_plane)) & mlwg_pkg::LANE_MASK;
        if (slot_end) begin
          if (current_is_last) begin
            mode_next        = mlwg_pkg::MODE_GUARD;
            guard_count_next = '0;
          end else if (word_valid) begin
            res.taken            = 1'b1;
            current_plane_next   = bit_plane;
            current_is_last_next = plane_last;
            slot_tick_next       = '0;
          end else begin
            res.under        = 1'b1;
            mode_next        = mlwg_pkg::MODE_GUARD;
            guard_count_next = '0;
          end
        end else begin
          slot_tick_next = slot_inc[mlwg_pkg::TICK_W-1:0];
        end
      end
      mlwg_pkg::MODE_GUARD: begin
        res.busy = 1'b1;
        if (guard_end) begin
          res.done         = 1'b1;
          mode_next        = mlwg_pkg::MODE_IDLE;
          guard_count_next = '0;
        end else begin
          guard_count_next = guard_inc[mlwg_pkg::GUARD_W-1:0];
        end
      end
      default: begin
        // idle, and any unused code, waits for the first plane
        mode_next = mlwg_pkg::MODE_IDLE;
        if (word_valid) begin
          res.taken            = 1'b1;
          current_plane_next   = bit_plane;
          current_is_last_next = plane_last;
          slot_tick_next       = '0;
          mode_next            = mlwg_pkg::MODE_SEND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= mlwg_pkg::MODE_IDLE;
      slot_tick       <= '0;
      guard_count     <= '0;
      current_plane   <= '0;
      current_is_last <= 1'b0;
    end else if (step) begin
      mode            <= mode_next;
      slot_tick       <= slot_tick_next;
      guard_count     <= guard_count_next;
      current_plane   <= current_plane_next;
      current_is_last <= current_is_last_next;
    end
  end

endmodule

/* hw/rtl/multi_lane_led_waveform_gen.sv */
// Parallel LED data waveform generator, one tick of line timing per transfer.
// Input channel (in_valid / in_stall): each transfer is one waveform tick and
// may offer a bit-plane word (word_valid, bit_plane, plane_last). Output
// channel (out_valid / out_stall): one result per input transfer, carrying the
// pin levels of that tick plus word_taken, busy_res, frame_done and underrun.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets bit period,
// zero and one high times, guard time and the lane enable mask; write it only
// while the block is idle. cfg_ready is always high.
// The input register loads at the input transfer, the result register from it
// through the waveform logic when the output side is free. Throughput is one
// transfer per cycle while the receiver does not stall; the state update per
// tick is a single pass of compares and increments.
// Reset clears the line state to idle and loads the default timing and an
// empty lane mask. When the receiver stalls, the result holds, the waveform
// state freezes, and the input side stalls once its register is full.
module multi_lane_led_waveform_gen (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              word_valid,
  input  logic [mlwg_pkg::PIN_W-1:0]        bit_plane,
  input  logic                              plane_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mlwg_pkg::PIN_W-1:0]        pin_levels,
  output logic                              word_taken,
  output logic                              busy_res,
  output logic                              frame_done,
  output logic                              underrun,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlwg_pkg::CFG_DAT_W-1:0]    cfg_data
);

  `include "multi_lane_led_waveform_gen_assert.svh"

  mlwg_pkg::cfg_t                   cfg;
  mlwg_pkg::res_t                   res;
  logic                             in_full;
  logic                             in_word_valid;
  logic [mlwg_pkg::PIN_W-1:0]       in_plane;
  logic                             in_last;
  logic                             in_xfer;
  logic                             out_free;
  logic                             advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_full && out_free;
  assign in_stall  = in_full && !out_free;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period <= mlwg_pkg::RST_BIT_PERIOD;
      cfg.zero_high  <= mlwg_pkg::RST_ZERO_HIGH;
      cfg.one_high   <= mlwg_pkg::RST_ONE_HIGH;
      cfg.guard      <= mlwg_pkg::RST_GUARD;
      cfg.lane_en    <= mlwg_pkg::RST_LANE_EN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlwg_pkg::REG_BIT_PERIOD: cfg.bit_period <= cfg_data[mlwg_pkg::TICK_W-1:0];
        mlwg_pkg::REG_ZERO_HIGH:  cfg.zero_high  <= cfg_data[mlwg_pkg::TICK_W-1:0];
        mlwg_pkg::REG_ONE_HIGH:   cfg.one_high   <= cfg_data[mlwg_pkg::TICK_W-1:0];
        mlwg_pkg::REG_GUARD:      cfg.guard      <= cfg_data[mlwg_pkg::GUARD_W-1:0];
        mlwg_pkg::REG_LANE_EN:    cfg.lane_en    <= cfg_data[mlwg_pkg::PIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the tick until the result register can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_xfer) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_word_valid <= word_valid;
      in_plane      <= bit_plane;
      in_last       <= plane_last;
    end
  end

  mlwg_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cfg        (cfg),
    .word_valid (in_word_valid),
    .bit_plane  (in_plane),
    .plane_last (in_last),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pin_levels <= res.pins;
      word_taken <= res.taken;
      busy_res   <= res.busy;
      frame_done <= res.done;
      underrun   <= res.under;
    end
  end

  `MLWG_ASSERT_NXT(a_advance_fills_out, clk, rst, advance, out_valid)
  `MLWG_ASSERT_IMP(a_done_while_busy, clk, rst, out_valid && frame_done, busy_res)
  `MLWG_ASSERT_IMP(a_pins_only_busy, clk, rst, out_valid && (pin_levels != '0), busy_res)
  `MLWG_ASSERT_IMP(a_taken_not_under, clk, rst, out_valid && underrun, !word_taken)

endmodule

/* sim/multi_lane_led_waveform_gen_tb.sv */
module multi_lane_led_waveform_gen_tb;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 word_valid = 1'b0;
  logic [mlwg_pkg::PIN_W-1:0]           bit_plane = '0;
  logic                                 plane_last = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [mlwg_pkg::PIN_W-1:0]           pin_levels;
  logic                                 word_taken;
  logic                                 busy_res;
  logic                                 frame_done;
  logic                                 underrun;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [mlwg_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [mlwg_pkg::CFG_DAT_W-1:0]       cfg_data = '0;

  multi_lane_led_waveform_gen dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .word_valid (word_valid),
    .bit_plane  (bit_plane),
    .plane_last (plane_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pin_levels (pin_levels),
    .word_taken (word_taken),
    .busy_res   (busy_res),
    .frame_done (frame_done),
    .underrun   (underrun),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Line state and timing registers as the block should hold them
  mlwg_pkg::cfg_t   timing = '{mlwg_pkg::RST_BIT_PERIOD, mlwg_pkg::RST_ZERO_HIGH,
                               mlwg_pkg::RST_ONE_HIGH, mlwg_pkg::RST_GUARD,
                               mlwg_pkg::RST_LANE_EN};
  mlwg_pkg::mode_t  line_mode = mlwg_pkg::MODE_IDLE;
  logic [mlwg_pkg::TICK_W-1:0]  slot_pos = '0;
  logic [mlwg_pkg::GUARD_W-1:0] guard_pos = '0;
  logic [mlwg_pkg::PIN_W-1:0]   held_plane = '0;
  logic                         held_last = 1'b0;

  mlwg_pkg::res_t             pending_results[$];
  logic [mlwg_pkg::PIN_W-1:0] plane_list[$];

  int errors = 0;
  int cycles = 0;
  int ticks_checked = 0;
  int words_taken = 0;
  int frames_done = 0;
  int underruns = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // One waveform tick: work out the levels and flags, then advance the line state.
  task automatic advance_line(input logic wv, input logic [mlwg_pkg::PIN_W-1:0] plane,
                              input logic last, output mlwg_pkg::res_t r);
    logic [mlwg_pkg::PIN_W-1:0] en;
    logic [mlwg_pkg::PIN_W-1:0] ones;
    logic [mlwg_pkg::PIN_W-1:0] zeros;
    r = '0;
    en = timing.lane_en & mlwg_pkg::LANE_MASK;
    case (line_mode)
      mlwg_pkg::MODE_SEND: begin
        r.busy = 1'b1;
        ones = (slot_pos < timing.one_high) ? en : '0;
        zeros = (slot_pos < timing.zero_high && slot_pos < timing.one_high) ? en : '0;
        r.pins = (ones & held_plane) | (zeros & ~held_plane);
        if (int'(slot_pos) + 1 >= int'(timing.bit_period)) begin
          if (held_last) begin
            line_mode = mlwg_pkg::MODE_GUARD;
            guard_pos = '0;
          end else if (wv) begin
            r.taken = 1'b1;
            held_plane = plane;
            held_last = last;
            slot_pos = '0;
          end else begin
            r.under = 1'b1;
            line_mode = mlwg_pkg::MODE_GUARD;
            guard_pos = '0;
          end
        end else begin
          slot_pos = slot_pos + 1'b1;
        end
      end
      mlwg_pkg::MODE_GUARD: begin
        r.busy = 1'b1;
        if (int'(guard_pos) + 1 >= int'(timing.guard)) begin
          r.done = 1'b1;
          line_mode = mlwg_pkg::MODE_IDLE;
          guard_pos = '0;
        end else begin
          guard_pos = guard_pos + 1'b1;
        end
      end
      default: begin
        line_mode = mlwg_pkg::MODE_IDLE;
        if (wv) begin
          r.taken = 1'b1;
          held_plane = plane;
          held_last = last;
          slot_pos = '0;
          line_mode = mlwg_pkg::MODE_SEND;
        end
      end
    endcase
    r.pins = r.pins & mlwg_pkg::LANE_MASK;
  endtask

  // True on ticks where an offered word would be taken.
  function automatic bit word_wanted();
    if (line_mode == mlwg_pkg::MODE_SEND)
      return int'(slot_pos) + 1 >= int'(timing.bit_period) && !held_last;
    return line_mode != mlwg_pkg::MODE_GUARD;
  endfunction

  function automatic bit line_busy();
    return line_mode == mlwg_pkg::MODE_SEND || line_mode == mlwg_pkg::MODE_GUARD;
  endfunction

  task automatic send_tick(input logic wv, input logic [mlwg_pkg::PIN_W-1:0] plane,
                           input logic last);
    mlwg_pkg::res_t want;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    word_valid <= wv;
    bit_plane <= plane;
    plane_last <= last;
    advance_line(wv, plane, last, want);
    pending_results.push_back(want);
    do @(posedge clk); while (in_stall);
  endtask

  // Drop the input valid and wait until every result is back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer n ticks that carry no word, then settle.
  task automatic idle_ticks(input int n);
    logic [mlwg_pkg::PIN_W-1:0] noise;
    repeat (n) begin
      noise = $urandom();
      send_tick(1'b0, noise, noise[1]);
    end
    settle();
  endtask

  task automatic finish_frame();
    logic [mlwg_pkg::PIN_W-1:0] noise;
    while (line_busy()) begin
      noise = $urandom();
      send_tick(1'b0, noise, noise[3]);
    end
    settle();
  endtask

  task automatic write_reg(input logic [mlwg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mlwg_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mlwg_pkg::REG_BIT_PERIOD: timing.bit_period = data[mlwg_pkg::TICK_W-1:0];
      mlwg_pkg::REG_ZERO_HIGH:  timing.zero_high = data[mlwg_pkg::TICK_W-1:0];
      mlwg_pkg::REG_ONE_HIGH:   timing.one_high = data[mlwg_pkg::TICK_W-1:0];
      mlwg_pkg::REG_GUARD:      timing.guard = data[mlwg_pkg::GUARD_W-1:0];
      mlwg_pkg::REG_LANE_EN:    timing.lane_en = data[mlwg_pkg::PIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Write all five registers; junk puts random bits above each field's width.
  task automatic program_timing(input int period, input int zero_hi, input int one_hi,
                                input int guard, input logic [mlwg_pkg::PIN_W-1:0] lanes,
                                input bit junk);
    logic [mlwg_pkg::CFG_DAT_W-1:0] fill;
    fill = junk ? $urandom() : '0;
    write_reg(mlwg_pkg::REG_BIT_PERIOD,
              {fill[mlwg_pkg::CFG_DAT_W-1:mlwg_pkg::TICK_W], mlwg_pkg::TICK_W'(period)});
    fill = junk ? $urandom() : '0;
    write_reg(mlwg_pkg::REG_ZERO_HIGH,
              {fill[mlwg_pkg::CFG_DAT_W-1:mlwg_pkg::TICK_W], mlwg_pkg::TICK_W'(zero_hi)});
    fill = junk ? $urandom() : '0;
    write_reg(mlwg_pkg::REG_ONE_HIGH,
              {fill[mlwg_pkg::CFG_DAT_W-1:mlwg_pkg::TICK_W], mlwg_pkg::TICK_W'(one_hi)});
    fill = junk ? $urandom() : '0;
    write_reg(mlwg_pkg::REG_GUARD,
              {fill[mlwg_pkg::CFG_DAT_W-1:mlwg_pkg::GUARD_W], mlwg_pkg::GUARD_W'(guard)});
    write_reg(mlwg_pkg::REG_LANE_EN, lanes);
    end_writes();
  endtask

  // Send plane_list as one frame; noisy offers words on ticks where they must be ignored.
  task automatic drive_frame(input bit mark_last, input bit noisy);
    int sent;
    logic [mlwg_pkg::PIN_W-1:0] noise;
    sent = 0;
    while (sent < plane_list.size() || line_busy()) begin
      noise = $urandom();
      if (word_wanted() && sent < plane_list.size()) begin
        send_tick(1'b1, plane_list[sent], mark_last && sent == plane_list.size() - 1);
        sent++;
      end else if (noisy && !word_wanted()) begin
        send_tick(1'b1, noise, noise[0]);
      end else begin
        send_tick(1'b0, noise, noise[1]);
      end
    end
    settle();
  endtask

  // Mostly well-formed frames with random planes, plus ignored words and underruns.
  task automatic random_traffic(input int n);
    int roll;
    logic [mlwg_pkg::PIN_W-1:0] word;
    repeat (n) begin
      roll = $urandom_range(99);
      word = $urandom();
      if (word_wanted())
        send_tick(roll < 93, word, $urandom_range(4) == 0);
      else
        send_tick(roll < 25, word, word[7]);
    end
    finish_frame();
  endtask

  task automatic test_reset_defaults();
    // lanes are off after reset: the default slot goes out with every pin low
    send_tick(1'b1, 32'h1234_5678, 1'b1);
    idle_ticks(70);
    // the default guard has held for a while; shorten it and enable the lanes
    write_reg(mlwg_pkg::REG_LANE_EN, '1);
    write_reg(mlwg_pkg::REG_GUARD, 32'd8);
    end_writes();
    finish_frame();
    plane_list = {32'h0F0F_0F0F, 32'hFFFF_0000};
    drive_frame(1'b1, 1'b1);
  endtask

  task automatic test_code_shapes();
    program_timing(6, 2, 4, 3, '1, 1'b0);
    plane_list = {32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5};
    drive_frame(1'b1, 1'b1);
    // no last mark: the frame ends on an underrun
    program_timing(5, 1, 3, 2, 32'h00FF_F00F, 1'b0);
    plane_list = {32'hFFFF_FFFF, 32'h8000_0001};
    drive_frame(1'b0, 1'b1);
  endtask

  task automatic test_timing_corners();
    // zero bit period acts as a one-tick slot; zero guard still spends one tick
    program_timing(0, 0, 1, 0, '1, 1'b0);
    plane_list = {32'hC3C3_C3C3, 32'h3C3C_3C3C, 32'hFFFF_FFFF};
    drive_frame(1'b1, 1'b1);
    // zero high time past the one high time
    program_timing(8, 6, 3, 1, $urandom(), 1'b1);
    plane_list = {32'h0000_FFFF, 32'hFFFF_0000};
    drive_frame(1'b1, 1'b1);
    // high times past the slot end
    program_timing(4, 7, 9, 2, '1, 1'b1);
    plane_list = {32'h1111_1111, 32'hEEEE_EEEE};
    drive_frame(1'b1, 1'b1);
    program_timing(1, 1, 1, 1, '1, 1'b0);
    // unused register indexes must leave the timing alone
    for (int i = mlwg_pkg::REG_LANE_EN + 1; i < 2 ** mlwg_pkg::CFG_IDX_W; i++)
      write_reg(mlwg_pkg::CFG_IDX_W'(i), $urandom());
    end_writes();
    plane_list = {32'hDEAD_BEEF, 32'h0000_0000};
    drive_frame(1'b1, 1'b1);
  endtask

  task automatic test_slow_limits();
    idle_pct = 0;
    stall_pct <= 0;
    // longest slot and guard, each cut short by a register write once deep in
    program_timing(1023, 1023, 1023, 65535, '1, 1'b0);
    send_tick(1'b1, 32'h6969_9696, 1'b1);
    idle_ticks(50);
    write_reg(mlwg_pkg::REG_BIT_PERIOD, 32'd52);
    end_writes();
    idle_ticks(42);
    write_reg(mlwg_pkg::REG_GUARD, 32'd1);
    end_writes();
    finish_frame();
    // zero lanes low from the slot start, one lanes high to the slot end
    program_timing(40, 0, 1023, 0, '1, 1'b0);
    plane_list = {32'h6969_9696, 32'h0000_0001};
    drive_frame(1'b1, 1'b0);
  endtask

  task automatic test_random_phases();
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 71, 0, 32};
    stall_tab = '{0, 0, 71, 32};
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct <= stall_tab[p];
      repeat (2) begin
        program_timing(($urandom_range(5) == 0) ? 0 : $urandom_range(1, 10),
                       $urandom_range(12), $urandom_range(12), $urandom_range(16),
                       ($urandom_range(3) == 0) ? '1 : $urandom(), 1'b1);
        random_traffic(60);
      end
    end
  endtask

  task automatic test_long_hold();
    idle_pct = 0;
    stall_pct <= 0;
    program_timing(3, 1, 2, 4, '1, 1'b0);
    hold_reqs <= hold_reqs + 1;
    random_traffic(120);
  endtask

  // Receiver: random stalls, or a long counted hold when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic compare_field(input string field, input logic [mlwg_pkg::PIN_W-1:0] want,
                               input logic [mlwg_pkg::PIN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    mlwg_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got pins %h flags %b%b%b%b", $time,
                 pin_levels, word_taken, busy_res, frame_done, underrun);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("pin_levels", want.pins, pin_levels);
        compare_field("word_taken", mlwg_pkg::PIN_W'(want.taken),
                      mlwg_pkg::PIN_W'(word_taken));
        compare_field("busy_res", mlwg_pkg::PIN_W'(want.busy), mlwg_pkg::PIN_W'(busy_res));
        compare_field("frame_done", mlwg_pkg::PIN_W'(want.done),
                      mlwg_pkg::PIN_W'(frame_done));
        compare_field("underrun", mlwg_pkg::PIN_W'(want.under), mlwg_pkg::PIN_W'(underrun));
        ticks_checked++;
        words_taken += int'(want.taken);
        frames_done += int'(want.done);
        underruns += int'(want.under);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results pending", cycles,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_code_shapes();
    test_timing_corners();
    test_slow_limits();
    test_random_phases();
    test_long_hold();
    settle();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("checked %0d ticks: %0d words taken, %0d frames done, %0d underruns",
             ticks_checked, words_taken, frames_done, underruns);
    $display("timing corners, idle/stall phases and a long output hold exercised, %0d errors",
             errors);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
